[sv/u2u_pkg.sv]
// Shared types, constants and the code-point to UTF-16 conversion.
`timescale 1ns / 1ps
`default_nettype none
package u2u_pkg;

    localparam logic [31:0] MAX_SCALAR = 32'h0010_FFFF;
    localparam logic [31:0] MAX_BMP    = 32'h0000_FFFF;
    localparam logic [20:0] PLANE1     = 21'h01_0000;
    localparam logic [15:0] SURR_LO    = 16'hD800;
    localparam logic [15:0] SURR_HI    = 16'hDC00;
    localparam logic [15:0] SURR_END   = 16'hE000;

    typedef struct packed {
        logic [1:0]  cnt;
        logic [15:0] u0;
        logic [15:0] u1;
    } t_conv;

    typedef struct packed {
        logic [3:0][15:0] units;
        logic [1:0]       last;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    function automatic t_conv to_utf16(input logic [31:0] u);
        t_conv       r;
        logic [20:0] off;
        r   = '0;
        off = u[20:0] - PLANE1;
        priority if (u > MAX_SCALAR) begin
            r.cnt = 2'd0;
        end else if (u > MAX_BMP) begin
            r.cnt = 2'd2;
            r.u0  = SURR_LO + {6'd0, off[19:10]};
            r.u1  = SURR_HI | {6'd0, u[9:0]};
        end else if (u[15:0] < SURR_LO || u[15:0] >= SURR_END) begin
            r.cnt = 2'd1;
            r.u0  = u[15:0];
        end else begin
            r.cnt = 2'd0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[sv/utf8_to_utf16_decoder.sv]
// Top level of the UTF-8 to UTF-16 stream decoder.
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_stall  i_in_byte, i_end_of_string
//   output   out        o_valid / i_stall  o_code_unit, o_last_unit
//
// One byte is taken per cycle while the job queue has room; a byte yields 0 to 4 units.
// Units leave one per cycle from the output register while i_stall is low and jobs are queued.
// A job is registered in the queue and then in the output register before its first unit leaves.
// Reset clears the accumulator, pending flag, queue and output valid.
// o_stall rises only when the queue is full; i_stall holds the current unit.
`timescale 1ns / 1ps
`default_nettype none
module utf8_to_utf16_decoder
    import u2u_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_end_of_string,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_code_unit,
    output logic             o_last_unit
);

    t_job    f_job, q_job;
    t_q_stat q_stat;
    logic    push, pop, accept;

    assign o_stall = q_stat.full;
    assign accept  = i_valid && !o_stall;

    u2u_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .o_job           (f_job),
        .o_push          (push)
    );

    u2u_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    u2u_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_job),
        .i_stat      (q_stat),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_code_unit (o_code_unit),
        .o_last_unit (o_last_unit)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !q_stat.full)
        else $error("output or queue busy after reset");

    a_held_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_code_unit))
        else $error("stalled unit changed");

endmodule
`default_nettype wire

[sv/u2u_front.sv]
// Front end: byte classification, accumulator and per-byte unit job build.
`timescale 1ns / 1ps
`default_nettype none
module u2u_front
    import u2u_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_string,
    output t_job            o_job,
    output logic            o_push
);

    logic [31:0] r_accum, n_accum, acc_upd;
    logic        r_pending, n_pending;
    logic        is_cont;
    t_conv       v0, v1, c0, c1;
    logic [2:0]  total;

    always_comb begin
        is_cont = (i_in_byte[7:6] == 2'b10);
        priority if (i_in_byte <= 8'h7F) begin
            acc_upd = {24'd0, i_in_byte};
        end else if (i_in_byte <= 8'hBF) begin
            acc_upd = {r_accum[25:0], i_in_byte[5:0]};
        end else if (i_in_byte <= 8'hDF) begin
            acc_upd = {27'd0, i_in_byte[4:0]};
        end else if (i_in_byte <= 8'hEF) begin
            acc_upd = {28'd0, i_in_byte[3:0]};
        end else begin
            acc_upd = {29'd0, i_in_byte[2:0]};
        end
        c0 = to_utf16(r_accum);
        c1 = to_utf16(acc_upd);
        v0 = (r_pending && !is_cont) ? c0 : '0;
        v1 = i_end_of_string ? c1 : '0;
        n_accum   = i_end_of_string ? 32'd0 : acc_upd;
        n_pending = !i_end_of_string;

        o_job.units[0] = (v0.cnt != 2'd0) ? v0.u0 : v1.u0;
        o_job.units[1] = (v0.cnt == 2'd2) ? v0.u1 : (v0.cnt == 2'd1) ? v1.u0 : v1.u1;
        o_job.units[2] = (v0.cnt == 2'd2) ? v1.u0 : v1.u1;
        o_job.units[3] = v1.u1;
        total          = {1'b0, v0.cnt} + {1'b0, v1.cnt};
        o_job.last     = 2'(total - 3'd1);
        o_push         = i_accept && (total != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum   <= '0;
            r_pending <= 1'b0;
        end else if (i_accept) begin
            r_accum   <= n_accum;
            r_pending <= n_pending;
        end
    end

endmodule
`default_nettype wire

[sv/u2u_fifo.sv]
// Job queue between front end and output serializer.
`timescale 1ns / 1ps
`default_nettype none
module u2u_fifo
    import u2u_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output t_q_stat   o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    always_comb begin
        o_job        = r_mem[r_rd];
        o_stat.empty = (r_cnt == '0);
        o_stat.full  = (r_cnt == FULL_CNT);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

[sv/u2u_back.sv]
// Back end: output register that serializes one job into code units.
`timescale 1ns / 1ps
`default_nettype none
module u2u_back
    import u2u_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_job    i_job,
    input  wire t_q_stat i_stat,
    output logic       o_pop,
    input  wire logic  i_stall,
    output logic       o_valid,
    output logic [15:0] o_code_unit,
    output logic       o_last_unit
);

    t_job       r_job;
    logic [1:0] r_idx;
    logic       r_valid;
    logic       at_last, load;

    always_comb begin
        at_last     = (r_idx == r_job.last);
        load        = !r_valid || (!i_stall && at_last);
        o_pop       = load && !i_stat.empty;
        o_valid     = r_valid;
        o_code_unit = r_job.units[r_idx];
        o_last_unit = at_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= !i_stat.empty;
            r_idx   <= '0;
        end else if (!i_stall) begin
            r_idx   <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

endmodule
`default_nettype wire
